// ----- hw/rtl/ext_clock_tempo_estimator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the external clock tempo estimator
// Clocked on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EXT_CLOCK_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH
`define EXT_CLOCK_TEMPO_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define ECTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ecte_pkg.sv -----
// ----------------------------------------------------------------------------
// ecte_pkg
// Types and constants shared by the tempo estimator controller and datapath.
// ----------------------------------------------------------------------------
package ecte_pkg;

  localparam int unsigned TS_W  = 48;  // timestamp / period width
  localparam int unsigned S_W   = 56;  // Q8 smoothed period width
  localparam int unsigned MPB_W = 63;  // smoothed period times pulses per beat
  localparam int unsigned MB_W  = 20;  // milli-BPM width
  localparam int unsigned Q_W   = 44;  // quotient width
  localparam int unsigned CFG_W = 32;

  localparam logic [Q_W-1:0]  NUM_Q8     = 44'd15360000000000; // 60e9 * 256
  localparam logic [5:0]      DIV_MSB    = 6'd43;
  localparam logic [MB_W-1:0] TEMPO_MIN  = 20'd1000;
  localparam logic [MB_W-1:0] TEMPO_MAX  = 20'd999000;
  localparam logic [6:0]      PPQ_MAX    = 7'd96;
  localparam logic [6:0]      PPQ_RST    = 7'd24;
  localparam logic [1:0]      LONG_LAST  = 2'd2;   // third long period in a row
  localparam logic [3:0]      RUN_MAX    = 4'd15;

  localparam logic [1:0] REG_PPQ     = 2'd0;
  localparam logic [1:0] REG_HYST    = 2'd1;
  localparam logic [1:0] REG_SETTLE  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MED_GATE,
    ST_GATE,
    ST_INSERT,
    ST_MED_EMA,
    ST_EMA,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_HYST,
    ST_CHECK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic start;
    logic anchor_set;
    logic period_load;
    logic med_run;
    logic long_rej;
    logic insert;
    logic ema;
    logic mul;
    logic div_run;
    logic clamp;
    logic hyst;
    logic check;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_check;
    logic anchor_valid;
    logic ts_not_after;
    logic fill_ge3;
    logic med_found;
    logic short_rej;
    logic long_rej;
    logic ins_ge3;
    logic s_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/ext_clock_tempo_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// ext_clock_tempo_estimator_unit
// Tempo estimate in milli-BPM from external clock pulse timestamps.
//
//   channel | signals                                     | direction
//   in      | in_valid_i/in_ready_o, action_i, timestamp_us_i | to block
//   out     | out_valid_o/out_ready_i, tempo_update_o,      | from block
//           |   tempo_mbpm_o, clock_active_o                |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i               | to block
//
// One item at a time. From transfer in to result valid, a check item passes
// the dispatch, check and result states; a pulse may run two median searches
// (one window entry ranked per cycle) and the 44-step restoring divider for
// the tempo quotient. The next item may transfer in as the result turns valid.
// Reset clears history and loads register defaults; no clearing pass.
// A stalled result stays in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "ext_clock_tempo_estimator_unit_defines.svh"

module ext_clock_tempo_estimator_unit import ecte_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [TS_W-1:0]  timestamp_us_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             tempo_update_o,
  output logic [MB_W-1:0]  tempo_mbpm_o,
  output logic             clock_active_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  ecte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecte_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .timestamp_us_i (timestamp_us_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tempo_update_o (tempo_update_o),
    .tempo_mbpm_o   (tempo_mbpm_o),
    .clock_active_o (clock_active_o)
  );

  `ECTE_ASSERT_NXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "took a second item")
  `ECTE_ASSERT_IMP(a_no_update_zero, out_valid_o && !tempo_update_o, tempo_mbpm_o == '0, "stray tempo")
  `ECTE_ASSERT_IMP(a_update_range, out_valid_o && tempo_update_o, (tempo_mbpm_o >= TEMPO_MIN) && (tempo_mbpm_o <= TEMPO_MAX), "tempo out of range")
  `ECTE_ASSERT_IMP(a_kind_excl, out_valid_o, !(tempo_update_o && clock_active_o), "pulse and check flags both set")

endmodule

// ----- hw/rtl/ecte_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecte_ctrl
// Sequencer for one item: walks pulse or check handling through the datapath.
// ----------------------------------------------------------------------------
module ecte_ctrl import ecte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts_i.is_check) begin
          state_d = ST_CHECK;
        end else if (!sts_i.anchor_valid || sts_i.ts_not_after) begin
          state_d = ST_RESULT;
        end else if (sts_i.fill_ge3) begin
          state_d = ST_MED_GATE;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_MED_GATE: if (sts_i.med_found) state_d = ST_GATE;
      ST_GATE: begin
        if (sts_i.short_rej || sts_i.long_rej) state_d = ST_RESULT;
        else state_d = ST_INSERT;
      end
      ST_INSERT:   state_d = sts_i.ins_ge3 ? ST_MED_EMA : ST_RESULT;
      ST_MED_EMA:  if (sts_i.med_found) state_d = ST_EMA;
      ST_EMA:      state_d = ST_MUL;
      ST_MUL:      state_d = sts_i.s_zero ? ST_RESULT : ST_DIV;
      ST_DIV:      if (sts_i.div_last) state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_HYST;
      ST_HYST:     state_d = ST_RESULT;
      ST_CHECK:    state_d = ST_RESULT;
      ST_RESULT:   if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.start   = in_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.anchor_set  = !sts_i.is_check && !sts_i.anchor_valid;
        cmd_o.period_load = 1'b1;
      end
      ST_MED_GATE, ST_MED_EMA: cmd_o.med_run = 1'b1;
      ST_GATE:     cmd_o.long_rej = !sts_i.short_rej && sts_i.long_rej;
      ST_INSERT:   cmd_o.insert = 1'b1;
      ST_EMA:      cmd_o.ema = 1'b1;
      ST_MUL:      cmd_o.mul = 1'b1;
      ST_DIV:      cmd_o.div_run = 1'b1;
      ST_CLAMP:    cmd_o.clamp = 1'b1;
      ST_HYST:     cmd_o.hyst = 1'b1;
      ST_CHECK:    cmd_o.check = 1'b1;
      ST_RESULT:   cmd_o.out_load = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule

// ----- hw/rtl/ecte_dp.sv -----
// ----------------------------------------------------------------------------
// ecte_dp
// Datapath: period window, median search, EMA, multiply, restoring divider,
// hysteresis, activity check, configuration and output register.
// ----------------------------------------------------------------------------
module ecte_dp import ecte_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             action_i,
  input  logic [TS_W-1:0]  timestamp_us_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             tempo_update_o,
  output logic [MB_W-1:0]  tempo_mbpm_o,
  output logic             clock_active_o
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  // configuration
  logic [6:0]       ppq_q;
  logic [9:0]       hdiv_q;
  logic [3:0]       settle_q;
  logic [CFG_W-1:0] min_to_q;

  // history
  logic [TS_W-1:0]   last_q;
  logic              anchor_q;
  logic [IDX_W-1:0]  widx_q;
  logic [FILL_W-1:0] fill_q;
  logic [1:0]        run_q;
  logic [S_W-1:0]    s_q;
  logic [MB_W-1:0]   pub_q, cand_q;
  logic [3:0]        crun_q;

  // working registers
  logic              act_q;
  logic [TS_W-1:0]   t_q, period_q, med_q;
  logic [TS_W-1:0]   win_q [WINDOW_DEPTH];
  logic [IDX_W-1:0]  midx_q;
  logic [MPB_W-1:0]  mpb_q;
  logic [MPB_W-1:0]  rem_q;
  logic [Q_W-1:0]    quo_q;
  logic [5:0]        dcnt_q;
  logic [MB_W-1:0]   mbpm_q;
  logic              res_upd_q, res_act_q;
  logic [MB_W-1:0]   res_mb_q;
  logic              out_valid_q, out_upd_q, out_act_q;
  logic [MB_W-1:0]   out_mb_q;

  // median search: one candidate per cycle, ranked against the filled window entries
  logic [TS_W-1:0]   cand_v;
  logic [FILL_W-1:0] n_lt, n_le, half;
  logic              med_found;

  always_comb begin
    cand_v = win_q[midx_q];
    n_lt   = '0;
    n_le   = '0;
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      if (FILL_W'(j) < fill_q) begin
        if (win_q[j] < cand_v)  n_lt = n_lt + FILL_W'(1);
        if (win_q[j] <= cand_v) n_le = n_le + FILL_W'(1);
      end
    end
    half      = fill_q >> 1;
    med_found = (n_lt <= half) && (n_le > half);
  end

  // window bookkeeping
  logic [FILL_W-1:0] fill_inc;
  logic [IDX_W-1:0]  widx_inc;
  assign fill_inc = (fill_q == FILL_W'(WINDOW_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign widx_inc = (widx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : widx_q + IDX_W'(1);

  // EMA, gain 1/8, truncating toward zero
  logic [S_W-1:0]        mq8, s_ema;
  logic signed [S_W:0]   ema_diff, ema_step;
  always_comb begin
    mq8      = {med_q, 8'h00};
    ema_diff = $signed({1'b0, mq8}) - $signed({1'b0, s_q});
    ema_step = ema_diff[S_W] ? ((ema_diff + 57'sd7) >>> 3) : (ema_diff >>> 3);
    s_ema    = (s_q == '0) ? mq8 : s_q + ema_step[S_W-1:0];
  end

  logic [MPB_W-1:0] mpb_d;
  assign mpb_d = MPB_W'(s_q) * MPB_W'(ppq_q);

  // restoring divider, one quotient bit per cycle
  logic [MPB_W:0]   rem_sh;
  logic             rem_ge;
  logic [MPB_W-1:0] rem_d;
  always_comb begin
    rem_sh = {rem_q, NUM_Q8[DIV_MSB - dcnt_q]};
    rem_ge = rem_sh >= {1'b0, mpb_q};
    rem_d  = rem_ge ? MPB_W'(rem_sh - {1'b0, mpb_q}) : rem_sh[MPB_W-1:0];
  end

  logic [MB_W-1:0] mbpm_d;
  always_comb begin
    if (quo_q < Q_W'(TEMPO_MIN))      mbpm_d = TEMPO_MIN;
    else if (quo_q > Q_W'(TEMPO_MAX)) mbpm_d = TEMPO_MAX;
    else                              mbpm_d = quo_q[MB_W-1:0];
  end

  // hysteresis against published and candidate tempo
  logic [MB_W-1:0]  dif_p, dif_c;
  logic [29:0]      prod_p, prod_c;
  logic             in_band, cand_match, publish_now;
  logic [3:0]       run_new;
  always_comb begin
    dif_p       = (mbpm_q > pub_q) ? mbpm_q - pub_q : pub_q - mbpm_q;
    dif_c       = (mbpm_q > cand_q) ? mbpm_q - cand_q : cand_q - mbpm_q;
    prod_p      = 30'(dif_p) * 30'(hdiv_q);
    prod_c      = 30'(dif_c) * 30'(hdiv_q);
    in_band     = prod_p <= 30'(pub_q);
    cand_match  = (cand_q != '0) && (prod_c <= 30'(cand_q));
    run_new     = cand_match ? ((crun_q == RUN_MAX) ? RUN_MAX : crun_q + 4'd1) : 4'd1;
    publish_now = run_new >= settle_q;
  end

  // activity check
  logic [TS_W-1:0] expect_p, elapsed;
  logic [TS_W+1:0] exp4, tmo;
  logic            timed_out;
  always_comb begin
    expect_p  = s_q[S_W-1:8];
    exp4      = {expect_p, 2'b00};
    tmo       = ((expect_p != '0) && (exp4 > (TS_W+2)'(min_to_q))) ? exp4
                : (TS_W+2)'(min_to_q);
    elapsed   = t_q - last_q;
    timed_out = (t_q > last_q) && ({2'b00, elapsed} > tmo);
  end

  logic [6:0] ppq_w;
  always_comb begin
    ppq_w = cfg_data_i[6:0];
    if (ppq_w == 7'd0)        ppq_w = 7'd1;
    else if (ppq_w > PPQ_MAX) ppq_w = PPQ_MAX;
  end

  logic clr_hist;
  assign clr_hist = (cfg_we_i && cfg_idx_i == REG_PPQ && ppq_w != ppq_q)
                  || (cmd_i.long_rej && run_q == LONG_LAST)
                  || (cmd_i.check && anchor_q && timed_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppq_q       <= PPQ_RST;
      hdiv_q      <= 10'd100;
      settle_q    <= 4'd3;
      min_to_q    <= 32'd500000;
      last_q      <= '0;
      anchor_q    <= 1'b0;
      widx_q      <= '0;
      fill_q      <= '0;
      run_q       <= '0;
      s_q         <= '0;
      pub_q       <= '0;
      cand_q      <= '0;
      crun_q      <= '0;
      midx_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PPQ:     ppq_q    <= ppq_w;
          REG_HYST:    hdiv_q   <= cfg_data_i[9:0];
          REG_SETTLE:  settle_q <= cfg_data_i[3:0];
          REG_TIMEOUT: min_to_q <= cfg_data_i;
          default:     ppq_q    <= ppq_q;
        endcase
      end
      if (clr_hist) begin
        // a long-period clear re-anchors below
        if (!cmd_i.long_rej) begin
          last_q   <= '0;
          anchor_q <= 1'b0;
        end
        widx_q   <= '0;
        fill_q   <= '0;
        run_q    <= '0;
        s_q      <= '0;
        pub_q    <= '0;
        cand_q   <= '0;
        crun_q   <= '0;
      end
      if (cmd_i.anchor_set) begin
        last_q   <= t_q;
        anchor_q <= 1'b1;
      end
      if (cmd_i.long_rej) begin
        last_q <= t_q;
        // third in a row: history already cleared above, re-anchor here
        if (run_q == LONG_LAST) anchor_q <= 1'b1;
        else                    run_q    <= run_q + 2'd1;
      end
      if (cmd_i.insert) begin
        run_q  <= '0;
        last_q <= t_q;
        widx_q <= widx_inc;
        fill_q <= fill_inc;
      end
      if (cmd_i.ema) s_q <= s_ema;
      midx_q <= (cmd_i.med_run && !med_found) ? midx_q + IDX_W'(1) : '0;
      dcnt_q <= cmd_i.div_run ? dcnt_q + 6'd1 : '0;
      if (cmd_i.hyst) begin
        if (pub_q == '0) begin
          pub_q <= mbpm_q;
        end else if (in_band) begin
          crun_q <= '0;
        end else if (publish_now) begin
          pub_q  <= mbpm_q;
          cand_q <= '0;
          crun_q <= '0;
        end else begin
          if (!cand_match) cand_q <= mbpm_q;
          crun_q <= run_new;
        end
      end
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q     <= action_i;
      t_q       <= timestamp_us_i;
      res_upd_q <= 1'b0;
      res_mb_q  <= '0;
      res_act_q <= 1'b0;
    end
    if (cmd_i.period_load) period_q <= t_q - last_q;
    if (cmd_i.med_run && med_found) med_q <= cand_v;
    if (cmd_i.insert) win_q[widx_q] <= period_q;
    if (cmd_i.mul) mpb_q <= mpb_d;
    if (cmd_i.div_run) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[Q_W-2:0], rem_ge};
    end else begin
      rem_q <= '0;
    end
    if (cmd_i.clamp) mbpm_q <= mbpm_d;
    if (cmd_i.hyst && ((pub_q == '0) || (!in_band && publish_now))) begin
      res_upd_q <= 1'b1;
      res_mb_q  <= mbpm_q;
    end
    if (cmd_i.check) res_act_q <= anchor_q && !timed_out;
    if (cmd_i.out_load) begin
      out_upd_q <= res_upd_q;
      out_mb_q  <= res_mb_q;
      out_act_q <= res_act_q;
    end
  end

  always_comb begin
    sts_o.is_check     = act_q;
    sts_o.anchor_valid = anchor_q;
    sts_o.ts_not_after = t_q <= last_q;
    sts_o.fill_ge3     = fill_q >= FILL_W'(3);
    sts_o.med_found    = med_found;
    sts_o.short_rej    = period_q < (med_q >> 1);
    sts_o.long_rej     = {1'b0, period_q} > {med_q, 1'b0};
    sts_o.ins_ge3      = fill_inc >= FILL_W'(3);
    sts_o.s_zero       = s_q == '0;
    sts_o.div_last     = dcnt_q == DIV_MSB;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign tempo_update_o = out_upd_q;
  assign tempo_mbpm_o   = out_mb_q;
  assign clock_active_o = out_act_q;

endmodule
